FILE: rtl/core/cttok_pkg.sv
// Package for the config text tokenizer: widths, scan modes, token kinds,
// character codes, the token record and the character class functions.
// No dependencies.
`default_nettype none

package cttok_pkg;

  localparam int POS_W         = 24;
  localparam int LINE_W        = 24;
  localparam int VAL_W         = 32;
  localparam int KIND_W        = 3;
  localparam int COLOUR_W      = 24;
  localparam int COLOUR_DIGITS = 6;
  localparam int COLOUR_SPAN   = 7;
  localparam int QUEUE_DEPTH   = 3;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [VAL_W-1:0]  VAL_MAX  = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_A  = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_COLOUR,
    MODE_NUMBER,
    MODE_WORD
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    TOK_NUMBER     = 3'd0,
    TOK_COLOUR     = 3'd1,
    TOK_STRING     = 3'd2,
    TOK_WORD       = 3'd3,
    TOK_EOF        = 3'd4,
    TOK_UNTERM     = 3'd5,
    TOK_BAD_COLOUR = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [LINE_W-1:0] line;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic              last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_skip(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE) ||
           (c == CH_FF) || (c == CH_VT) || (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           is_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF_A)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (is_digit(c)) begin
      t = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LF_A)) begin
      t = c - CH_LA + 8'd10;
    end else begin
      t = c - CH_UA + 8'd10;
    end
    return t[3:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? POS_MAX : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cttok_ifs.sv
// Valid/ready channel interfaces for the tokenizer: source bytes in, tokens out.
// Depends on cttok_pkg for field widths.
`default_nettype none

interface cttok_in_if;
  import cttok_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface cttok_out_if;
  import cttok_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [LINE_W-1:0] token_line;
  logic [VAL_W-1:0]  token_value;
  logic [POS_W-1:0]  span_start;
  logic [POS_W-1:0]  span_length;
  logic              last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_value,
                  output span_start, output span_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_line, input token_value,
                input span_start, input span_length, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cttok_scan.sv
// Scanner state and per-byte token logic: one byte per step, up to two tokens out.
// Depends on cttok_pkg.
`default_nettype none

module cttok_scan
  import cttok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] text_byte,
  output token_t          tok0,
  output token_t          tok1,
  output logic [1:0]      tok_cnt
);

  mode_t             mode_r, mode_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [2:0]        hex_r, hex_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  tstart_r, tstart_nxt;
  logic [LINE_W-1:0] tline_r, tline_nxt;

  logic                again;
  logic                eof_hit;
  logic [POS_W-1:0]    span_len;
  logic [COLOUR_W-1:0] colour_acc;
  logic [VAL_W+3:0]    num_sum;
  token_t              lead;
  token_t              eof_tok;

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    hex_nxt    = hex_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    again      = 1'b0;
    eof_hit    = 1'b0;
    tok0       = '0;
    tok1       = '0;
    tok_cnt    = 2'd0;

    span_len   = pos_r - tstart_r;
    colour_acc = {acc_r[COLOUR_W-5:0], hex_nibble(text_byte)};
    num_sum    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                 (VAL_W+4)'(text_byte - CH_0);

    lead       = '0;
    lead.line  = tline_r;
    lead.start = tstart_r;
    lead.len   = span_len;

    eof_tok       = '0;
    eof_tok.kind  = TOK_EOF;
    eof_tok.line  = line_r;
    eof_tok.start = pos_r;

    case (mode_r)
      MODE_STRING: begin
        if (text_byte == CH_NUL) begin
          tok0      = lead;
          tok0.kind = TOK_UNTERM;
          tok_cnt   = 2'd1;
          mode_nxt  = MODE_IDLE;
          again     = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          tok0      = lead;
          tok0.kind = TOK_STRING;
          tok_cnt   = 2'd1;
          mode_nxt  = MODE_IDLE;
        end else if ((text_byte == CH_LF) && (line_r != LINE_MAX)) begin
          line_nxt = line_r + 1'b1;
        end
      end
      MODE_COLOUR: begin
        if (!is_hex(text_byte)) begin
          tok0      = lead;
          tok0.kind = TOK_BAD_COLOUR;
          tok_cnt   = 2'd1;
          mode_nxt  = MODE_IDLE;
          again     = 1'b1;
        end else begin
          acc_nxt = VAL_W'(colour_acc);
          hex_nxt = hex_r + 3'd1;
          if (hex_r == 3'(COLOUR_DIGITS - 1)) begin
            tok0       = lead;
            tok0.kind  = TOK_COLOUR;
            tok0.value = VAL_W'({colour_acc[7:0], colour_acc[15:8], colour_acc[23:16]});
            tok0.len   = POS_W'(COLOUR_SPAN);
            tok_cnt    = 2'd1;
            mode_nxt   = MODE_IDLE;
            hex_nxt    = 3'd0;
          end
        end
      end
      MODE_NUMBER: begin
        if (is_digit(text_byte)) begin
          acc_nxt = (num_sum[VAL_W+3:VAL_W] != 4'd0) ? VAL_MAX : num_sum[VAL_W-1:0];
        end else begin
          tok0       = lead;
          tok0.kind  = TOK_NUMBER;
          tok0.value = acc_r;
          tok_cnt    = 2'd1;
          mode_nxt   = MODE_IDLE;
          again      = 1'b1;
        end
      end
      MODE_WORD: begin
        if (!is_word_char(text_byte)) begin
          tok0      = lead;
          tok0.kind = TOK_WORD;
          tok_cnt   = 2'd1;
          mode_nxt  = MODE_IDLE;
          again     = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        again    = 1'b1;
      end
    endcase

    if (again) begin
      if (is_skip(text_byte)) begin
        if ((text_byte == CH_LF) && (line_r != LINE_MAX)) begin
          line_nxt = line_r + 1'b1;
        end
      end else if (text_byte == CH_NUL) begin
        eof_hit = 1'b1;
        if (tok_cnt == 2'd0) begin
          tok0 = eof_tok;
        end else begin
          tok1 = eof_tok;
        end
        tok_cnt    = tok_cnt + 2'd1;
        mode_nxt   = MODE_IDLE;
        acc_nxt    = '0;
        hex_nxt    = 3'd0;
        line_nxt   = LINE_W'(1);
        pos_nxt    = '0;
        tstart_nxt = '0;
        tline_nxt  = LINE_W'(1);
      end else begin
        tstart_nxt = pos_r;
        tline_nxt  = line_r;
        acc_nxt    = '0;
        hex_nxt    = 3'd0;
        if (text_byte == CH_QUOTE) begin
          mode_nxt   = MODE_STRING;
          tstart_nxt = pos_inc(pos_r);
        end else if (text_byte == CH_HASH) begin
          mode_nxt = MODE_COLOUR;
        end else if (is_digit(text_byte)) begin
          mode_nxt = MODE_NUMBER;
          acc_nxt  = VAL_W'(text_byte - CH_0);
        end else begin
          mode_nxt = MODE_WORD;
        end
      end
    end

    if (!eof_hit) begin
      pos_nxt = pos_inc(pos_r);
    end

    if (tok_cnt == 2'd1) begin
      tok0.last = 1'b1;
    end else if (tok_cnt == 2'd2) begin
      tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      hex_r    <= 3'd0;
      line_r   <= LINE_W'(1);
      pos_r    <= '0;
      tstart_r <= '0;
      tline_r  <= LINE_W'(1);
    end else if (step) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      hex_r    <= hex_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    step && eof_hit |=> (pos_r == '0) && (line_r == LINE_W'(1)))
    else $error("position or line not rewound after end of source");

  a_second_is_eof: assert property (@(posedge clk) disable iff (!rst_n)
    tok_cnt == 2'd2 |-> (tok1.kind == TOK_EOF) && !tok0.last && tok1.last)
    else $error("second token of a byte is not a final end of source");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (tline_r != '0))
    else $error("line counter reached zero");

  a_colour_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_COLOUR |-> hex_r < 3'(COLOUR_DIGITS))
    else $error("colour digit count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/config_text_tokenizer.sv
// Top level of the config text tokenizer: input byte register, scanner and
// result queue. Depends on cttok_pkg, cttok_ifs and cttok_scan.
`default_nettype none

// Takes one source byte per cycle on in_chan and delivers tokens on out_chan.
// A byte is registered, scanned once the result queue has room and its tokens
// are queued. Most bytes yield zero or one token; a 0 byte that ends a number,
// word, bad colour or string yields that token and then the end-of-source
// token. The scanner advances only when the three-entry result queue has room
// for two tokens, which sustains one byte per cycle while the sink takes at
// least one token per cycle.
module config_text_tokenizer
  import cttok_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  cttok_in_if.sink    in_chan,
  cttok_out_if.source out_chan
);

  logic       byte_v_r, byte_v_nxt;
  logic [7:0] byte_r;

  token_t     q_r [QUEUE_DEPTH];
  token_t     q_nxt [QUEUE_DEPTH];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] cnt_after;

  logic       pop;
  logic       fire;
  logic       in_acc;

  token_t     tok0;
  token_t     tok1;
  logic [1:0] tok_cnt;

  assign pop       = out_chan.valid && out_chan.ready;
  assign cnt_after = q_cnt_r - {1'b0, pop};
  assign fire      = byte_v_r && (cnt_after <= 2'd1);
  assign in_chan.ready = !byte_v_r || fire;
  assign in_acc    = in_chan.valid && in_chan.ready;

  cttok_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .text_byte (byte_r),
    .tok0      (tok0),
    .tok1      (tok1),
    .tok_cnt   (tok_cnt)
  );

  always_comb begin
    byte_v_nxt = byte_v_r;
    if (in_acc) begin
      byte_v_nxt = 1'b1;
    end else if (fire) begin
      byte_v_nxt = 1'b0;
    end

    q_cnt_nxt = fire ? cnt_after + tok_cnt : cnt_after;

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (fire && (tok_cnt != 2'd0) && (2'(i) == cnt_after)) begin
        q_nxt[i] = tok0;
      end
      if (fire && (tok_cnt == 2'd2) && (2'(i) == cnt_after + 2'd1)) begin
        q_nxt[i] = tok1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      byte_v_r <= byte_v_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_chan.text_byte;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_chan.valid       = (q_cnt_r != 2'd0);
  assign out_chan.token_kind  = q_r[0].kind;
  assign out_chan.token_line  = q_r[0].line;
  assign out_chan.token_value = q_r[0].value;
  assign out_chan.span_start  = q_r[0].start;
  assign out_chan.span_length = q_r[0].len;
  assign out_chan.last_of_run = q_r[0].last;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (32'(cnt_after) + 32'(tok_cnt)) <= QUEUE_DEPTH)
    else $error("result queue overflow");

  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    byte_v_r && !fire |=> byte_v_r && $stable(byte_r))
    else $error("pending byte lost before scan");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !fire |=> q_cnt_r == $past(q_cnt_r) - 2'd1)
    else $error("queue count wrong after pop");
`endif

endmodule

`default_nettype wire

FILE: test/config_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for config_text_tokenizer: drives source bytes, predicts
// each byte's tokens in step with the scanner and checks them on the token channel.
// Depends on cttok_pkg, cttok_ifs and the tokenizer RTL.

module config_text_tokenizer_tb;
  import cttok_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int BODY_BYTES    = 1550;
  localparam int MAX_REPORTS   = 100;

  typedef struct {
    logic [7:0] text_byte;
    bit         drain_first;
  } source_byte_t;

  logic clk;
  logic rst_n;

  cttok_in_if  in_if();
  cttok_out_if out_if();

  config_text_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  source_byte_t pending_bytes[$];
  token_t       tokens_due[$];
  int           mismatch_count;
  int           tokens_seen;
  int           body_count;
  bit           drain_next;

  // scanner state as the tokenizer should hold it
  mode_t             scan_state;
  logic [VAL_W-1:0]  acc_value;
  int                hex_count;
  logic [LINE_W-1:0] cur_line;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  tok_start;
  logic [LINE_W-1:0] tok_line;

  int gap_left;
  int src_calm;
  int stall_left;
  int sink_calm;
  int idle_cycles;

  always #10 clk = ~clk;

  function automatic bit blank_byte(input logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SPACE ||
           c == CH_FF || c == CH_VT || c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ident_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_byte(c) || c == "_";
  endfunction

  function automatic bit hex_byte(input logic [7:0] c);
    return digit_byte(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (digit_byte(c)) begin
      v = c - "0";
    end else if (c >= "a") begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [POS_W-1:0] bump_pos(input logic [POS_W-1:0] p);
    return (&p) ? p : p + 1'b1;
  endfunction

  function automatic token_t make_token(input kind_t kind, input logic [LINE_W-1:0] line,
                                        input logic [VAL_W-1:0] value,
                                        input logic [POS_W-1:0] start,
                                        input logic [POS_W-1:0] len);
    token_t t;
    t.kind  = kind;
    t.line  = line;
    t.value = value;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic clear_scanner();
    scan_state = MODE_IDLE;
    acc_value  = '0;
    hex_count  = 0;
    cur_line   = LINE_W'(1);
    cur_pos    = '0;
    tok_start  = '0;
    tok_line   = LINE_W'(1);
  endtask

  task automatic open_token(input mode_t mode);
    scan_state = mode;
    tok_start  = cur_pos;
    tok_line   = cur_line;
    acc_value  = '0;
    hex_count  = 0;
  endtask

  // Advance the scanner by one byte and queue the tokens it yields.
  task automatic predict_tokens(input logic [7:0] c);
    token_t           staged[2];
    int               n;
    bit               rescan;
    bit               at_eof;
    logic [35:0]      wide;
    logic [POS_W-1:0] span;
    n      = 0;
    rescan = 1'b0;
    at_eof = 1'b0;
    span   = cur_pos - tok_start;
    case (scan_state)
      MODE_STRING: begin
        if (c == CH_NUL) begin
          staged[n] = make_token(TOK_UNTERM, tok_line, '0, tok_start, span);
          n++;
          scan_state = MODE_IDLE;
          rescan = 1'b1;
        end else if (c == CH_QUOTE) begin
          staged[n] = make_token(TOK_STRING, tok_line, '0, tok_start, span);
          n++;
          scan_state = MODE_IDLE;
        end else if (c == CH_LF && !(&cur_line)) begin
          cur_line++;
        end
      end
      MODE_COLOUR: begin
        if (!hex_byte(c)) begin
          staged[n] = make_token(TOK_BAD_COLOUR, tok_line, '0, tok_start, span);
          n++;
          scan_state = MODE_IDLE;
          rescan = 1'b1;
        end else begin
          acc_value = {8'h00, acc_value[19:0], hex_digit(c)};
          hex_count++;
          if (hex_count >= COLOUR_DIGITS) begin
            staged[n] = make_token(TOK_COLOUR, tok_line,
                                   {8'h00, acc_value[7:0], acc_value[15:8], acc_value[23:16]},
                                   tok_start, POS_W'(COLOUR_SPAN));
            n++;
            scan_state = MODE_IDLE;
            hex_count  = 0;
          end
        end
      end
      MODE_NUMBER: begin
        if (digit_byte(c)) begin
          wide = acc_value * 36'd10 + 36'(c - CH_0);
          acc_value = (wide > {4'h0, VAL_MAX}) ? VAL_MAX : wide[VAL_W-1:0];
        end else begin
          staged[n] = make_token(TOK_NUMBER, tok_line, acc_value, tok_start, span);
          n++;
          scan_state = MODE_IDLE;
          rescan = 1'b1;
        end
      end
      MODE_WORD: begin
        if (!ident_byte(c)) begin
          staged[n] = make_token(TOK_WORD, tok_line, '0, tok_start, span);
          n++;
          scan_state = MODE_IDLE;
          rescan = 1'b1;
        end
      end
      default: begin
        scan_state = MODE_IDLE;
        rescan = 1'b1;
      end
    endcase

    if (rescan) begin
      if (blank_byte(c)) begin
        if (c == CH_LF && !(&cur_line)) cur_line++;
      end else if (c == CH_NUL) begin
        staged[n] = make_token(TOK_EOF, cur_line, '0, cur_pos, '0);
        n++;
        clear_scanner();
        at_eof = 1'b1;
      end else if (c == CH_QUOTE) begin
        open_token(MODE_STRING);
        tok_start = bump_pos(cur_pos);
      end else if (c == CH_HASH) begin
        open_token(MODE_COLOUR);
      end else if (digit_byte(c)) begin
        open_token(MODE_NUMBER);
        acc_value = VAL_W'(c - CH_0);
      end else begin
        open_token(MODE_WORD);
      end
    end

    if (!at_eof) cur_pos = bump_pos(cur_pos);
    if (n > 0) staged[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) tokens_due.push_back(staged[i]);
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) calm = $urandom_range(30, 150);
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: token %0d %s: got 0x%0h, want 0x%0h",
               $time, tokens_seen, what, got, want);
  endtask

  task automatic add_byte(input logic [7:0] b);
    source_byte_t item;
    item.text_byte   = b;
    item.drain_first = drain_next;
    drain_next       = 1'b0;
    pending_bytes.push_back(item);
    body_count++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  always @(posedge clk) begin : drive_bytes
    logic         next_valid;
    source_byte_t item;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      clear_scanner();
      gap_left = 0;
    end else begin
      next_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_tokens(in_if.text_byte);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain_first && tokens_due.size() > 0)) begin
          item = pending_bytes.pop_front();
          in_if.text_byte <= item.text_byte;
          next_valid = 1'b1;
          gap_left = pick_gap(src_calm);
        end
      end
      in_if.valid <= next_valid;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap(sink_calm);
      out_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected, kind", out_if.token_kind, '0);
      end else begin
        want = tokens_due.pop_front();
        if (out_if.token_kind !== want.kind)
          report_mismatch("kind", out_if.token_kind, want.kind);
        if (out_if.token_line !== want.line)
          report_mismatch("line", out_if.token_line, want.line);
        if (out_if.token_value !== want.value)
          report_mismatch("value", out_if.token_value, want.value);
        if (out_if.span_start !== want.start)
          report_mismatch("span start", out_if.span_start, want.start);
        if (out_if.span_length !== want.len)
          report_mismatch("span length", out_if.span_length, want.len);
        if (out_if.last_of_run !== want.last)
          report_mismatch("last of run", out_if.last_of_run, want.last);
      end
      tokens_seen++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    string      hex_chars;
    string      ident_chars;
    int         sel;
    int         len;
    logic [7:0] b;
    hex_chars   = "0123456789abcdefABCDEF";
    ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.text_byte = 8'h00;
    out_if.ready = 1'b0;
    mismatch_count = 0;
    tokens_seen = 0;
    body_count = 0;
    drain_next = 1'b0;
    src_calm = 0;
    sink_calm = 0;
    idle_cycles = 0;

    // saturating number, good colour, short colour, string across a line feed,
    // byte 255 as a word, skips, unterminated string followed by end of source
    add_text("5000000000#aB09fF#1z'");
    add_byte(CH_LF);
    add_text("'");
    add_byte(8'hFF);
    add_byte(CH_TAB);
    add_text(",;'");
    add_byte(CH_NUL);

    drain_next = 1'b1;
    body_count = 0;
    while (body_count < BODY_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
      end else if (sel < 32) begin
        add_byte(CH_HASH);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : COLOUR_DIGITS;
        for (int i = 0; i < len; i++) add_byte(hex_chars[$urandom_range(0, 21)]);
      end else if (sel < 46) begin
        add_byte(CH_QUOTE);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            add_byte(CH_LF);
          end else begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
            add_byte(b);
          end
        end
        add_byte(($urandom_range(0, 7) == 0) ? CH_NUL : CH_QUOTE);
      end else if (sel < 64) begin
        if ($urandom_range(0, 2) != 0) begin
          add_byte(ident_chars[$urandom_range(0, 51)]);
        end else begin
          do b = 8'($urandom_range(1, 255));
          while (blank_byte(b) || digit_byte(b) || b == CH_QUOTE || b == CH_HASH);
          add_byte(b);
        end
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) add_byte(ident_chars[$urandom_range(0, 62)]);
      end else if (sel < 84) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0: add_byte(CH_CR);
            1: add_byte(CH_LF);
            2: add_byte(CH_TAB);
            3: add_byte(CH_SPACE);
            4: add_byte(CH_FF);
            5: add_byte(CH_VT);
            6: add_byte(CH_COMMA);
            default: add_byte(CH_SEMI);
          endcase
        end
      end else if (sel < 92) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 95) begin
        add_byte(CH_NUL);
      end else if (sel < 97) begin
        drain_next = 1'b1;
      end else begin
        add_byte(CH_SPACE);
      end
    end
    add_byte(CH_NUL);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_if.valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cttok_pkg.sv
rtl/core/cttok_ifs.sv
rtl/core/cttok_scan.sv
rtl/core/config_text_tokenizer.sv
test/config_text_tokenizer_tb.sv
